/* sv/rpc_pkg.sv */
// ============================================================================
// rpc_pkg: shared definitions for the red pixel centroid core
// Field widths, register indexes, reset values and default size limits.
// ============================================================================
package rpc_pkg;

    // Width of one color component of a pixel.
    localparam int PIX_W = 8;

    // Width of the frame size registers.
    localparam int CFG_W = 11;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Widths of the result fields.
    localparam int CENT_W  = 10;
    localparam int COUNT_W = 21;

    // Default limits on the frame size.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Reset values of the frame size registers.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

endpackage

/* sv/red_pixel_centroid_core.sv */
// ============================================================================
// red_pixel_centroid_core: centroid of the red pixels in a raster frame
// Counts red pixels of a row-major RGB stream, sums their columns and rows,
// and at the end of every frame divides the sums by the count on one shared
// bit-serial divider to give the rounded mean position.
// ============================================================================
//
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------------------
//  in      | in_valid / in_stall        | red, green, blue
//  out     | out_valid / out_stall      | centroid_x, centroid_y, red_count,
//          |                            | found
//  cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A pixel is taken in every cycle while a frame is running. The last pixel of
// a frame starts the divider, which runs one quotient bit per cycle, first for
// the column and then for the row (QD bits each, QD = clog2 of the larger
// limit): in_stall stays high through the divider states and DONE, and DONE
// waits while the output holds the previous result. A frame without red
// pixels skips the divider and goes straight to DONE. The result waits in the
// output register while the next frame's pixels come in. Reset clears the
// position, sums and count and restores 640 by 480. cfg_ready is always high.
module red_pixel_centroid_core #(
    parameter int MAX_WIDTH  = rpc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rpc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Pixel stream.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rpc_pkg::PIX_W-1:0]     red,
    input  logic [rpc_pkg::PIX_W-1:0]     green,
    input  logic [rpc_pkg::PIX_W-1:0]     blue,
    // Frame results.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rpc_pkg::CENT_W-1:0]    centroid_x,
    output logic [rpc_pkg::CENT_W-1:0]    centroid_y,
    output logic [rpc_pkg::COUNT_W-1:0]   red_count,
    output logic                          found,
    // Configuration writes.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpc_pkg::CFG_W-1:0]     cfg_data
);

    // Position, count and sum widths.
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int NCW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SXW   = CW + NCW;
    localparam int SYW   = RW + NCW;
    // Divider widths: quotient bits, divisor bits and numerator bits.
    localparam int QD    = (CW > RW) ? CW : RW;
    localparam int DW    = NCW + 1;
    localparam int NUMW  = QD + DW + 1;
    localparam int STW   = $clog2(QD + 1);
    // Width that holds both a size register and a size limit.
    localparam int WSZ_A = $clog2(MAX_WIDTH + 1);
    localparam int WSZ   = (WSZ_A > rpc_pkg::CFG_W) ? WSZ_A : rpc_pkg::CFG_W;
    localparam int HSZ_A = $clog2(MAX_HEIGHT + 1);
    localparam int HSZ   = (HSZ_A > rpc_pkg::CFG_W) ? HSZ_A : rpc_pkg::CFG_W;
    localparam int CENT_W  = rpc_pkg::CENT_W;
    localparam int COUNT_W = rpc_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_RUN,
        S_INIT_X,
        S_DIV_X,
        S_INIT_Y,
        S_DIV_Y,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [rpc_pkg::CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [rpc_pkg::CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [CW-1:0]             column_reg, column_next;
    logic [RW-1:0]             row_reg, row_next;
    logic [SXW-1:0]            sum_x_reg, sum_x_next;
    logic [SYW-1:0]            sum_y_reg, sum_y_next;
    logic [NCW-1:0]            count_reg, count_next;
    logic [DW:0]               rem_reg, rem_next;
    logic [QD-1:0]             num_reg, num_next;
    logic [QD-1:0]             quot_reg, quot_next;
    logic [QD-1:0]             qx_reg, qx_next;
    logic [STW-1:0]            step_reg, step_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CENT_W-1:0]         centroid_x_reg, centroid_x_next;
    logic [CENT_W-1:0]         centroid_y_reg, centroid_y_next;
    logic [COUNT_W-1:0]        red_count_reg, red_count_next;
    logic                      found_reg, found_next;

    logic [WSZ-1:0]            w_raw, w_eff;
    logic [HSZ-1:0]            h_raw, h_eff;
    logic                      last_col, last_row, is_red;
    logic [SXW-1:0]            sum_x_add;
    logic [SYW-1:0]            sum_y_add;
    logic [NCW-1:0]            count_add;
    logic [NUMW-1:0]           num_full;
    logic [DW-1:0]             divisor;
    logic [DW:0]               rem_shift;
    logic                      rem_ge;
    logic [QD-1:0]             quot_shift;

    // Effective frame size, saturated into the supported range.
    always_comb
    begin
        w_raw = WSZ'(frame_width_reg);
        h_raw = HSZ'(frame_height_reg);
        if (w_raw == '0)
            w_eff = WSZ'(1);
        else if (w_raw > WSZ'(MAX_WIDTH))
            w_eff = WSZ'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw == '0)
            h_eff = HSZ'(1);
        else if (h_raw > HSZ'(MAX_HEIGHT))
            h_eff = HSZ'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    // Pixel classification and end-of-row and end-of-frame detection.
    assign is_red   = ({1'b0, red[rpc_pkg::PIX_W-1:1]} > green) &&
                      ({1'b0, red[rpc_pkg::PIX_W-1:1]} > blue);
    assign last_col = (WSZ'(column_reg) + WSZ'(1)) >= w_eff;
    assign last_row = (HSZ'(row_reg) + HSZ'(1)) >= h_eff;

    // Accumulators with the current pixel included.
    assign sum_x_add = is_red ? sum_x_reg + SXW'(column_reg) : sum_x_reg;
    assign sum_y_add = is_red ? sum_y_reg + SYW'(row_reg) : sum_y_reg;
    assign count_add = is_red ? count_reg + NCW'(1) : count_reg;

    // Shared divider: numerator 2*sum + n over divisor 2*n, one bit a cycle.
    always_comb
    begin
        if (state_reg == S_INIT_X)
            num_full = NUMW'({sum_x_reg, 1'b0}) + NUMW'(count_reg);
        else
            num_full = NUMW'({sum_y_reg, 1'b0}) + NUMW'(count_reg);
    end
    assign divisor    = {count_reg, 1'b0};
    assign rem_shift  = {rem_reg[DW-1:0], num_reg[QD-1]};
    assign rem_ge     = rem_shift >= {1'b0, divisor};
    assign quot_shift = QD'({quot_reg, rem_ge});

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        column_next       = column_reg;
        row_next          = row_reg;
        sum_x_next        = sum_x_reg;
        sum_y_next        = sum_y_reg;
        count_next        = count_reg;
        rem_next          = rem_reg;
        num_next          = num_reg;
        quot_next         = quot_reg;
        qx_next           = qx_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg;
        centroid_x_next   = centroid_x_reg;
        centroid_y_next   = centroid_y_reg;
        red_count_next    = red_count_reg;
        found_next        = found_reg;

        // Register writes; an unknown index is ignored.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rpc_pkg::REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                rpc_pkg::REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end

        // The held result leaves once the receiver takes it.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_RUN:
            begin
                if (in_valid)
                begin
                    sum_x_next = sum_x_add;
                    sum_y_next = sum_y_add;
                    count_next = count_add;
                    if (!last_col)
                        column_next = column_reg + CW'(1);
                    else
                    begin
                        column_next = '0;
                        if (!last_row)
                            row_next = row_reg + RW'(1);
                        else
                        begin
                            row_next  = '0;
                            qx_next   = '0;
                            quot_next = '0;
                            state_next = (count_add == '0) ? S_DONE : S_INIT_X;
                        end
                    end
                end
            end
            S_INIT_X, S_INIT_Y:
            begin
                rem_next   = num_full[NUMW-1:QD];
                num_next   = num_full[QD-1:0];
                quot_next  = '0;
                step_next  = STW'(QD - 1);
                state_next = (state_reg == S_INIT_X) ? S_DIV_X : S_DIV_Y;
            end
            S_DIV_X, S_DIV_Y:
            begin
                rem_next  = rem_ge ? rem_shift - {1'b0, divisor} : rem_shift;
                num_next  = QD'({num_reg, 1'b0});
                quot_next = quot_shift;
                if (step_reg == '0)
                begin
                    if (state_reg == S_DIV_X)
                    begin
                        qx_next    = quot_shift;
                        state_next = S_INIT_Y;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                    step_next = step_reg - STW'(1);
            end
            S_DONE:
            begin
                // Load the result once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    centroid_x_next = CENT_W'(qx_reg);
                    centroid_y_next = CENT_W'(quot_reg);
                    red_count_next  = COUNT_W'(count_reg);
                    found_next      = (count_reg != '0);
                    sum_x_next      = '0;
                    sum_y_next      = '0;
                    count_next      = '0;
                    state_next      = S_RUN;
                end
            end
            default:
                state_next = S_RUN;
        endcase
    end

    // State, datapath and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_RUN;
            frame_width_reg  <= rpc_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rpc_pkg::FRAME_HEIGHT_RST;
            column_reg       <= '0;
            row_reg          <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            count_reg        <= '0;
            rem_reg          <= '0;
            num_reg          <= '0;
            quot_reg         <= '0;
            qx_reg           <= '0;
            step_reg         <= '0;
            out_valid_reg    <= 1'b0;
            centroid_x_reg   <= '0;
            centroid_y_reg   <= '0;
            red_count_reg    <= '0;
            found_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            sum_x_reg        <= sum_x_next;
            sum_y_reg        <= sum_y_next;
            count_reg        <= count_next;
            rem_reg          <= rem_next;
            num_reg          <= num_next;
            quot_reg         <= quot_next;
            qx_reg           <= qx_next;
            step_reg         <= step_next;
            out_valid_reg    <= out_valid_next;
            centroid_x_reg   <= centroid_x_next;
            centroid_y_reg   <= centroid_y_next;
            red_count_reg    <= red_count_next;
            found_reg        <= found_next;
        end
    end

    // Port drive.
    assign in_stall   = (state_reg != S_RUN);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign centroid_x = centroid_x_reg;
    assign centroid_y = centroid_y_reg;
    assign red_count  = red_count_reg;
    assign found      = found_reg;

    // A new result appears only from the final sequencer step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the final step");

    // The partial remainder stays below the divisor during division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_X || state_reg == S_DIV_Y) |->
            (rem_reg < {1'b0, divisor}))
        else $error("divider remainder out of range");

    // A frame without red pixels gives an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |->
            (centroid_x == '0 && centroid_y == '0 && red_count == '0))
        else $error("empty frame result is not zero");

    // The divider only starts on a frame with at least one red pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT_X) |-> (count_reg != '0))
        else $error("division started with a zero count");

endmodule

/* dv/rpc_checker.sv */
// ============================================================================
// rpc_checker: frame result scoreboard for the red pixel centroid core
// Watches the pixel, result and register channels and keeps its own model of
// the frame position, the red pixel sums and the size registers. Every
// predicted frame result is queued and compared field by field with the next
// result item that the core hands out.
// ============================================================================
module rpc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [rpc_pkg::PIX_W-1:0]     red,
    input  logic [rpc_pkg::PIX_W-1:0]     green,
    input  logic [rpc_pkg::PIX_W-1:0]     blue,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [rpc_pkg::CENT_W-1:0]    centroid_x,
    input  logic [rpc_pkg::CENT_W-1:0]    centroid_y,
    input  logic [rpc_pkg::COUNT_W-1:0]   red_count,
    input  logic                          found,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpc_pkg::CFG_W-1:0]     cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            frames_predicted,
    output int                            results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W   = rpc_pkg::PIX_W;
    localparam int CFG_W   = rpc_pkg::CFG_W;
    localparam int CENT_W  = rpc_pkg::CENT_W;
    localparam int COUNT_W = rpc_pkg::COUNT_W;

    typedef struct packed {
        logic [CENT_W-1:0]  cx;
        logic [CENT_W-1:0]  cy;
        logic [COUNT_W-1:0] cnt;
        logic               fnd;
    } centroid_t;

    // Shadow of the core's registers and frame state.
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [CFG_W-1:0]   column;
    logic [CFG_W-1:0]   row;
    logic [29:0]        sum_x;
    logic [29:0]        sum_y;
    logic [COUNT_W-1:0] hit_count;
    centroid_t          centroid_q[$];

    // Effective frame size: saturated into 1..limit.
    function automatic int clamp_dim(logic [CFG_W-1:0] v, int limit);
        if (v < 1)
            return 1;
        if (v > limit)
            return limit;
        return int'(v);
    endfunction

    // Mean rounded half up, in exact integer form.
    function automatic logic [CENT_W-1:0] rounded_mean(logic [29:0] sum,
                                                       logic [COUNT_W-1:0] n);
        logic [63:0] num;
        logic [63:0] den;
        num = 2 * 64'(sum) + 64'(n);
        den = 2 * 64'(n);
        return CENT_W'(num / den);
    endfunction

    task automatic flag_error(string msg);
        fail_count++;
        $display("rpc_checker: %s", msg);
    endtask

    // Advance the frame position by one pixel and queue a result at frame end.
    task automatic account_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] b);
        int               w;
        int               h;
        logic [PIX_W-1:0] half;
        centroid_t        res;
        w    = clamp_dim(width_reg, rpc_pkg::MAX_WIDTH_DEF);
        h    = clamp_dim(height_reg, rpc_pkg::MAX_HEIGHT_DEF);
        half = r >> 1;
        if (half > g && half > b)
        begin
            sum_x     = sum_x + column;
            sum_y     = sum_y + row;
            hit_count = hit_count + 1'b1;
        end
        if (int'(column) + 1 < w)
        begin
            column = column + 1'b1;
            return;
        end
        column = '0;
        if (int'(row) + 1 < h)
        begin
            row = row + 1'b1;
            return;
        end
        row = '0;
        res = '0;
        if (hit_count != 0)
        begin
            res.cx  = rounded_mean(sum_x, hit_count);
            res.cy  = rounded_mean(sum_y, hit_count);
            res.cnt = hit_count;
            res.fnd = 1'b1;
        end
        centroid_q.push_back(res);
        frames_predicted++;
        sum_x     = '0;
        sum_y     = '0;
        hit_count = '0;
    endtask

    // Compare one result item with the oldest predicted frame.
    task automatic check_result();
        centroid_t want;
        results_checked++;
        if (centroid_q.size() == 0)
        begin
            flag_error($sformatf("result x=%0d y=%0d count=%0d found=%0d with no frame pending",
                                 centroid_x, centroid_y, red_count, found));
            return;
        end
        want = centroid_q.pop_front();
        if (centroid_x !== want.cx)
            flag_error($sformatf("frame %0d: centroid_x %0d, expected %0d",
                                 results_checked, centroid_x, want.cx));
        if (centroid_y !== want.cy)
            flag_error($sformatf("frame %0d: centroid_y %0d, expected %0d",
                                 results_checked, centroid_y, want.cy));
        if (red_count !== want.cnt)
            flag_error($sformatf("frame %0d: red_count %0d, expected %0d",
                                 results_checked, red_count, want.cnt));
        if (found !== want.fnd)
            flag_error($sformatf("frame %0d: found %0d, expected %0d",
                                 results_checked, found, want.fnd));
    endtask

    // Sample all three channels at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = rpc_pkg::FRAME_WIDTH_RST;
            height_reg = rpc_pkg::FRAME_HEIGHT_RST;
            column     = '0;
            row        = '0;
            sum_x      = '0;
            sum_y      = '0;
            hit_count  = '0;
            centroid_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rpc_pkg::REG_FRAME_WIDTH:  width_reg  = cfg_data;
                    rpc_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                account_pixel(red, green, blue);
        end
        pending = centroid_q.size();
    end

endmodule

/* dv/tb.sv */
// ============================================================================
// tb: testbench top for the red pixel centroid core
// Drives pixel items and size register writes, stalls the result channel at
// random, and leaves prediction and comparison to rpc_checker. A directed
// opening covers the red threshold edges, rounding, zero and ignored register
// writes and a resize mid-frame; random frames follow under three idle mixes.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W     = rpc_pkg::PIX_W;
    localparam int CFG_W     = rpc_pkg::CFG_W;
    localparam int CFG_IDX_W = rpc_pkg::CFG_IDX_W;
    localparam int CENT_W    = rpc_pkg::CENT_W;
    localparam int COUNT_W   = rpc_pkg::COUNT_W;

    // Cycles the core may still be busy after the last result has come.
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEMS_PER_MODE = 250;

    // Register indexes that the core does not map.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef enum int {
        PIX_NOISE,
        PIX_REDDISH,
        PIX_EDGE,
        PIX_SATURATED
    } pix_style_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic                 out_valid;
    logic                 out_stall;
    logic [CENT_W-1:0]    centroid_x;
    logic [CENT_W-1:0]    centroid_y;
    logic [COUNT_W-1:0]   red_count;
    logic                 found;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int frames_predicted;
    int results_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;

    red_pixel_centroid_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .centroid_x (centroid_x),
        .centroid_y (centroid_y),
        .red_count  (red_count),
        .found      (found),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    rpc_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .centroid_x       (centroid_x),
        .centroid_y       (centroid_y),
        .red_count        (red_count),
        .found            (found),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .frames_predicted (frames_predicted),
        .results_checked  (results_checked)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("tb: FAIL");
        $finish;
    end

    // The result side stalls at random at every falling edge.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Pick one pixel; the styles aim at the red threshold from both sides.
    function automatic logic [3*PIX_W-1:0] pick_pixel(pix_style_t style);
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] half;
        r = PIX_W'($urandom);
        g = PIX_W'($urandom);
        b = PIX_W'($urandom);
        unique case (style)
            PIX_REDDISH:
            begin
                if ($urandom_range(4) != 0)
                begin
                    r    = PIX_W'($urandom_range(255, 128));
                    half = r >> 1;
                    g    = PIX_W'($urandom_range(half, 0));
                    b    = PIX_W'($urandom_range(half, 0));
                end
            end
            PIX_EDGE:
            begin
                half = r >> 1;
                g    = (half == 0 || $urandom_range(1) == 1) ? half : half - 1'b1;
                b    = PIX_W'($urandom_range(half, 0));
                if ($urandom_range(1) == 1)
                    {g, b} = {b, g};
            end
            PIX_SATURATED:
            begin
                r = {PIX_W{1'($urandom_range(1))}};
                g = {PIX_W{1'($urandom_range(1))}};
                b = {PIX_W{1'($urandom_range(1))}};
            end
            default: ;
        endcase
        return {r, g, b};
    endfunction

    // Frame sizes: mostly tiny, sometimes zero or a few dozen.
    function automatic logic [CFG_W-1:0] pick_dim();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'($urandom_range(40, 9));
            default: return CFG_W'($urandom_range(8, 1));
        endcase
    endfunction

    // Hand one pixel item to the core. Called and returns at a falling edge.
    task automatic send_pixel(logic [3*PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        {red, green, blue}  <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Send pixels until the current frame closes, wherever it stands.
    task automatic finish_frame(pix_style_t style);
        int base;
        base = frames_predicted;
        do
            send_pixel(pick_pixel(style));
        while (frames_predicted == base);
    endtask

    // Hold the input off until every result is out and the core is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        settle();
        write_reg(rpc_pkg::REG_FRAME_WIDTH, w);
        write_reg(rpc_pkg::REG_FRAME_HEIGHT, h);
    endtask

    // One large frame where only the very last pixel is red.
    task automatic sparse_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int n);
        logic [PIX_W-1:0] r;
        set_size(w, h);
        repeat (n - 1)
        begin
            r = PIX_W'($urandom);
            send_pixel({r, PIX_W'($urandom_range(255, r >> 1)), PIX_W'($urandom)});
        end
        send_pixel({8'd255, PIX_W'($urandom_range(126, 0)),
                    PIX_W'($urandom_range(126, 0))});
    endtask

    // Stimulus and verdict.
    initial
    begin
        pix_style_t       style;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int               mode_end;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        red           <= '0;
        green         <= '0;
        blue          <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= rpc_pkg::REG_FRAME_WIDTH;
        cfg_data      <= '0;
        items_sent    = 0;
        send_idle_pct = 25;
        recv_idle_pct = 65;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A few pixels at the reset size, then shrink the frame mid-row.
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd127, 8'd0});
        settle();
        write_reg(rpc_pkg::REG_FRAME_WIDTH, 11'd2);
        write_reg(rpc_pkg::REG_FRAME_HEIGHT, 11'd1);
        send_pixel({8'd200, 8'd10, 8'd10});

        // Zero size acts as one: every pixel is a frame of its own.
        set_size('0, '0);
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd127, 8'd0});
        send_pixel({8'd255, 8'd126, 8'd126});
        send_pixel({8'd200, 8'd0, 8'd100});
        send_pixel({8'd1, 8'd0, 8'd0});
        send_pixel({8'd254, 8'd126, 8'd126});
        send_pixel({8'd255, 8'd255, 8'd255});

        // Writes to unmapped indexes must leave the size alone.
        settle();
        write_reg(REG_UNMAPPED_LO, 11'h7FF);
        write_reg(REG_UNMAPPED_HI, 11'h7FF);
        set_size(11'd2, 11'd2);
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd0, 8'd0});

        // Half-way means round up.
        set_size(11'd3, 11'd1);
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd0});

        // Widest frame, saturated, putting the centroid at column 1023.
        sparse_frame(11'd2047, 11'd1, 1024);

        // Random frames under three idle mixes.
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 65 : 0;
            recv_idle_pct = (mode == 0) ? 65 : (mode == 1) ? 25 : 0;
            mode_end      = items_sent + ITEMS_PER_MODE;
            while (items_sent < mode_end)
            begin
                w = pick_dim();
                h = pick_dim();
                if ($urandom_range(24) == 0)
                begin
                    w = CFG_W'($urandom_range(200, 41));
                    h = CFG_W'($urandom_range(1, 0));
                end
                settle();
                if ($urandom_range(3) == 0)
                    write_reg(($urandom_range(1) == 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                              CFG_W'($urandom));
                write_reg(rpc_pkg::REG_FRAME_WIDTH, w);
                write_reg(rpc_pkg::REG_FRAME_HEIGHT, h);
                repeat ($urandom_range(4, 1))
                begin
                    style = pix_style_t'($urandom_range(3));
                    // Now and then the size changes part way through a frame.
                    if ($urandom_range(5) == 0)
                    begin
                        repeat ($urandom_range(5, 1))
                            send_pixel(pick_pixel(style));
                        settle();
                        write_reg(($urandom_range(1) == 1) ? rpc_pkg::REG_FRAME_HEIGHT
                                                           : rpc_pkg::REG_FRAME_WIDTH,
                                  pick_dim());
                    end
                    finish_frame(style);
                end
            end
        end

        settle();
        $display("tb: %0d pixel items sent, %0d frame results compared",
                 items_sent, results_checked);
        $display("tb: sizes from zero to saturated, resizes mid-frame, unmapped writes");
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/rpc_pkg.sv
sv/red_pixel_centroid_core.sv
dv/rpc_checker.sv
dv/tb.sv
